### design/nucleotide_kmer_composition_counter_macros.svh
// Assertion helpers shared by the RTL. Both expect signals named clock and reset
// in the scope where they are used.
`ifndef NUCLEOTIDE_KMER_COMPOSITION_COUNTER_MACROS_SVH
`define NUCLEOTIDE_KMER_COMPOSITION_COUNTER_MACROS_SVH

// Same-cycle implication.
`define NKC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NKC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/nkc_pkg.sv
package nkc_pkg;

   localparam int CHAR_BITS      = 8;
   localparam int IDX_BITS       = 7;
   localparam int OUT_BITS       = 48;
   localparam int CODE_BITS      = 2;
   localparam int CODE_LSB       = 1;
   localparam int MONO_DEPTH     = 4;
   localparam int DI_DEPTH       = 16;
   localparam int TRI_DEPTH      = 64;
   localparam int TOT_DEPTH      = 4;
   localparam int DI_ADDR_BITS   = 4;
   localparam int TRI_ADDR_BITS  = 6;
   localparam int TOT_ADDR_BITS  = 2;
   localparam int SUB_BITS       = 6;
   localparam int HIST_BITS      = 4;
   localparam int SEQ_POS_BITS   = 2;

   localparam logic [SEQ_POS_BITS-1:0] SEQ_POS_FIRST = 2'd0;
   localparam logic [SEQ_POS_BITS-1:0] SEQ_POS_MAX   = 2'd2;

   // counter_index map
   localparam logic [IDX_BITS-1:0] IDX_DI_LO  = 7'd4;
   localparam logic [IDX_BITS-1:0] IDX_TRI_LO = 7'd20;
   localparam logic [IDX_BITS-1:0] IDX_TOT_LO = 7'd84;
   localparam logic [IDX_BITS-1:0] IDX_END    = 7'd88;

   // position totals
   localparam logic [TOT_ADDR_BITS-1:0] TOT_MONO = 2'd0;
   localparam logic [TOT_ADDR_BITS-1:0] TOT_DI   = 2'd1;
   localparam logic [TOT_ADDR_BITS-1:0] TOT_TRI  = 2'd2;
   localparam logic [TOT_ADDR_BITS-1:0] TOT_SEQ  = 2'd3;

   typedef enum logic {
      REQ_BASE = 1'b0,
      REQ_READ = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      CAT_MONO,
      CAT_DI,
      CAT_TRI,
      CAT_TOTAL,
      CAT_NONE
   } cnt_cat_type;

   typedef struct packed {
      logic                     en;
      logic [TRI_ADDR_BITS-1:0] addr;
   } tri_wr_type;

endpackage

### design/nkc_if.sv
interface nkc_req_if;
   import nkc_pkg::*;

   logic                 valid;
   logic                 ready;
   req_kind_type         req_type;
   logic [CHAR_BITS-1:0] base_char;
   logic                 first_of_sequence;
   logic [IDX_BITS-1:0]  counter_index;

   modport source (
      output valid, req_type, base_char, first_of_sequence, counter_index,
      input  ready
   );
   modport sink (
      input  valid, req_type, base_char, first_of_sequence, counter_index,
      output ready
   );
endinterface

interface nkc_rsp_if;
   import nkc_pkg::*;

   logic                valid;
   logic                ready;
   logic [OUT_BITS-1:0] read_data;

   modport source (output valid, read_data, input ready);
   modport sink (input valid, read_data, output ready);
endinterface

### design/nucleotide_kmer_composition_counter.sv
// Mono/di/trinucleotide composition counter.
// req_if carries one beat per base character (req_type = REQ_BASE) or per counter
// read (req_type = REQ_READ). A base beat maps its character to a 2-bit code and
// bumps the mono, di and tri counters that its place in the sequence allows, plus
// the position totals; first_of_sequence starts a new sequence and bumps the
// sequence count. A read beat returns one counter on rsp_if, selected by
// counter_index (0-3 mono, 4-19 di, 20-83 tri, 84-86 totals, 87 sequences,
// zero above). All counters saturate at their maximum.
// Throughput: one beat per cycle of either kind while req_if.ready is high. A read
// passes through the input stage, then the result register, which drives
// rsp_if.valid. The tri counters sit in a 64-entry memory with one read and one
// write port; the read is issued at acceptance and the increment is written back
// in the following cycle, with a bypass so consecutive bases hitting the same
// entry count correctly.
// A read beat observes every base beat accepted before it.
// When rsp_if.ready is low the result register holds; base beats keep flowing,
// and only a second read finding the result register full stalls req_if.ready.
// Reset (synchronous) zeroes all counters, the base history and the sequence
// position; req_if.ready is low while reset is high.
module nucleotide_kmer_composition_counter #(
   parameter int COUNT_BITS = 48
) (
   input  logic       clock,
   input  logic       reset,
   nkc_req_if.sink    req_if,
   nkc_rsp_if.source  rsp_if
);
   import nkc_pkg::*;

   // input stage
   logic                       s1_valid_ff;
   req_kind_type               s1_kind_ff;
   logic [CODE_BITS-1:0]       s1_code_ff;
   logic [TRI_ADDR_BITS-1:0]   s1_tri_ff;
   logic                       s1_do_di_ff;
   logic                       s1_do_tri_ff;
   logic                       s1_first_ff;
   cnt_cat_type                s1_cat_ff;
   logic [SUB_BITS-1:0]        s1_sub_ff;

   // sequence context
   logic [HIST_BITS-1:0]       hist_ff;
   logic [SEQ_POS_BITS-1:0]    seq_pos_ff;

   // counters
   logic [COUNT_BITS-1:0]      mono_ff [MONO_DEPTH];
   logic [COUNT_BITS-1:0]      di_ff   [DI_DEPTH];
   logic [COUNT_BITS-1:0]      tot_ff  [TOT_DEPTH];

   // result register
   logic                       rsp_valid_ff;
   logic [OUT_BITS-1:0]        rsp_data_ff;
   logic [OUT_BITS-1:0]        rsp_data_in;

   logic                       accept;
   logic                       out_free;
   logic                       s1_hold;
   logic                       base_go;
   logic                       read_go;
   logic [CODE_BITS-1:0]       code_in;
   logic [SEQ_POS_BITS-1:0]    pos_in;
   logic [TRI_ADDR_BITS-1:0]   tri_in;
   cnt_cat_type                cat_in;
   logic [SUB_BITS-1:0]        sub_in;
   logic [TRI_ADDR_BITS-1:0]   mem_rd_addr;
   tri_wr_type                 tri_wr;
   logic [COUNT_BITS-1:0]      tri_rd;
   logic [COUNT_BITS-1:0]      tri_wr_data;
   logic [COUNT_BITS-1:0]      sel_count;

   // ---------------------------------------------------------------- handshake
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign s1_hold       = s1_valid_ff && (s1_kind_ff == REQ_READ) && !out_free;
   assign req_if.ready  = !s1_hold && !reset;
   assign accept        = req_if.valid && req_if.ready;
   assign base_go       = s1_valid_ff && (s1_kind_ff == REQ_BASE);
   assign read_go       = s1_valid_ff && (s1_kind_ff == REQ_READ) && out_free;

   // ---------------------------------------------------------------- decode
   assign code_in = req_if.base_char[CODE_LSB +: CODE_BITS];
   assign pos_in  = req_if.first_of_sequence ? SEQ_POS_FIRST : seq_pos_ff;
   assign tri_in  = {hist_ff, code_in};

   always_comb begin
      priority if (req_if.counter_index < IDX_DI_LO) begin
         cat_in = CAT_MONO;
         sub_in = SUB_BITS'(req_if.counter_index);
      end else if (req_if.counter_index < IDX_TRI_LO) begin
         cat_in = CAT_DI;
         sub_in = SUB_BITS'(req_if.counter_index - IDX_DI_LO);
      end else if (req_if.counter_index < IDX_TOT_LO) begin
         cat_in = CAT_TRI;
         sub_in = SUB_BITS'(req_if.counter_index - IDX_TRI_LO);
      end else if (req_if.counter_index < IDX_END) begin
         cat_in = CAT_TOTAL;
         sub_in = SUB_BITS'(req_if.counter_index - IDX_TOT_LO);
      end else begin
         cat_in = CAT_NONE;
         sub_in = '0;
      end
   end

   assign mem_rd_addr = (req_if.req_type == REQ_BASE) ? tri_in : TRI_ADDR_BITS'(sub_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!s1_hold) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff   <= req_if.req_type;
         s1_code_ff   <= code_in;
         s1_tri_ff    <= tri_in;
         s1_do_di_ff  <= (pos_in != SEQ_POS_FIRST);
         s1_do_tri_ff <= (pos_in == SEQ_POS_MAX);
         s1_first_ff  <= req_if.first_of_sequence;
         s1_cat_ff    <= cat_in;
         s1_sub_ff    <= sub_in;
      end
   end

   // history and position advance at acceptance of a base beat so the next beat sees them
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff    <= '0;
         seq_pos_ff <= SEQ_POS_FIRST;
      end else if (accept && (req_if.req_type == REQ_BASE)) begin
         hist_ff    <= tri_in[HIST_BITS-1:0];
         seq_pos_ff <= (pos_in == SEQ_POS_MAX) ? SEQ_POS_MAX : pos_in + SEQ_POS_BITS'(1);
      end
   end

   // ---------------------------------------------------------------- counters
   assign tri_wr.en    = base_go && s1_do_tri_ff;
   assign tri_wr.addr  = s1_tri_ff;
   assign tri_wr_data  = (tri_rd == '1) ? tri_rd : tri_rd + COUNT_BITS'(1);

   nkc_tri_mem #(
      .COUNT_BITS (COUNT_BITS)
   ) u_tri_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (mem_rd_addr),
      .wr      (tri_wr),
      .wr_data (tri_wr_data),
      .rd_data (tri_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MONO_DEPTH; i++) mono_ff[i] <= '0;
         for (int i = 0; i < DI_DEPTH; i++)   di_ff[i]   <= '0;
         for (int i = 0; i < TOT_DEPTH; i++)  tot_ff[i]  <= '0;
      end else if (base_go) begin
         for (int i = 0; i < MONO_DEPTH; i++) begin
            if ((s1_code_ff == CODE_BITS'(i)) && (mono_ff[i] != '1)) begin
               mono_ff[i] <= mono_ff[i] + COUNT_BITS'(1);
            end
         end
         for (int i = 0; i < DI_DEPTH; i++) begin
            if (s1_do_di_ff && (s1_tri_ff[DI_ADDR_BITS-1:0] == DI_ADDR_BITS'(i)) &&
                (di_ff[i] != '1)) begin
               di_ff[i] <= di_ff[i] + COUNT_BITS'(1);
            end
         end
         if (tot_ff[TOT_MONO] != '1) begin
            tot_ff[TOT_MONO] <= tot_ff[TOT_MONO] + COUNT_BITS'(1);
         end
         if (s1_do_di_ff && (tot_ff[TOT_DI] != '1)) begin
            tot_ff[TOT_DI] <= tot_ff[TOT_DI] + COUNT_BITS'(1);
         end
         if (s1_do_tri_ff && (tot_ff[TOT_TRI] != '1)) begin
            tot_ff[TOT_TRI] <= tot_ff[TOT_TRI] + COUNT_BITS'(1);
         end
         if (s1_first_ff && (tot_ff[TOT_SEQ] != '1)) begin
            tot_ff[TOT_SEQ] <= tot_ff[TOT_SEQ] + COUNT_BITS'(1);
         end
      end
   end

   // ---------------------------------------------------------------- read out
   always_comb begin
      unique case (s1_cat_ff)
         CAT_MONO:  sel_count = mono_ff[s1_sub_ff[TOT_ADDR_BITS-1:0]];
         CAT_DI:    sel_count = di_ff[s1_sub_ff[DI_ADDR_BITS-1:0]];
         CAT_TRI:   sel_count = tri_rd;
         CAT_TOTAL: sel_count = tot_ff[s1_sub_ff[TOT_ADDR_BITS-1:0]];
         default:   sel_count = '0;
      endcase
   end

   if (COUNT_BITS >= OUT_BITS) begin : g_out_trunc
      assign rsp_data_in = sel_count[OUT_BITS-1:0];
   end else begin : g_out_ext
      assign rsp_data_in = {{(OUT_BITS-COUNT_BITS){1'b0}}, sel_count};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (read_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (read_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.read_data = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   `include "nucleotide_kmer_composition_counter_macros.svh"

   `NKC_ASSERT_NOW(a_rsp_from_read, $rose(rsp_valid_ff), $past(s1_valid_ff && (s1_kind_ff == REQ_READ)), "result beat without a read in the input stage")
   `NKC_ASSERT_NEXT(a_read_held, s1_hold, s1_valid_ff && $stable(s1_cat_ff) && $stable(s1_sub_ff), "stalled read left the input stage")
   `NKC_ASSERT_NOW(a_seq_pos_range, 1'b1, seq_pos_ff <= SEQ_POS_MAX, "sequence position past saturation")
   `NKC_ASSERT_NOW(a_tri_needs_di, tri_wr.en, s1_do_di_ff && (tot_ff[TOT_MONO] != '0), "tri count without di and mono context")

endmodule

### design/nkc_tri_mem.sv
module nkc_tri_mem #(
   parameter int COUNT_BITS = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rd_en,
   input  logic [nkc_pkg::TRI_ADDR_BITS-1:0]    rd_addr,
   input  nkc_pkg::tri_wr_type                  wr,
   input  logic [COUNT_BITS-1:0]                wr_data,
   output logic [COUNT_BITS-1:0]                rd_data
);
   import nkc_pkg::*;

   logic [COUNT_BITS-1:0] mem [TRI_DEPTH];
   logic [TRI_DEPTH-1:0]  valid_ff;
   logic [COUNT_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr_data;
      end
   end

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // write-to-read bypass keeps back-to-back updates of one entry exact
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else if (valid_ff[rd_addr]) begin
            rd_data_ff <= mem[rd_addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule
